>>> design/ecg_period_heart_rate_assert.svh
// Assertion macros for the ECG period and heart-rate block.
// Used by design/ecg_period_heart_rate.sv; expects signals named clock and reset in scope.
`ifndef ECG_PERIOD_HEART_RATE_ASSERT_SVH
`define ECG_PERIOD_HEART_RATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ECGPHR_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ECGPHR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ecgphr_pkg.sv
// Shared constants for the ECG period and heart-rate block.
// No dependencies; imported by design/ecg_period_heart_rate.sv and verif/ecg_period_heart_rate_test.sv.
package ecgphr_pkg;

   localparam int WINDOW_DEFAULT = 256;

   localparam int SAMPLE_W = 10;
   localparam int THR_W    = 10;
   localparam int DEC_W    = 16;
   localparam int PER_W    = 16;
   localparam int BPM_W    = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 2'd2;

   // Reset values of the registers.
   localparam logic [DEC_W-1:0] DECIMATION_RST = 16'd0;
   localparam logic [THR_W-1:0] THRESHOLD_RST  = 10'd42;
   localparam logic [PER_W-1:0] PERIOD_RST     = 16'd42;

   // Command codes of the input word.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Milliseconds per minute, and the value reported for a zero period.
   localparam logic [BPM_W-1:0] BPM_NUMERATOR = 16'd60000;
   localparam logic [BPM_W-1:0] BPM_MAX       = 16'd60000;

endpackage

>>> design/ecg_period_heart_rate.sv
// ECG period and heart-rate block: sample decimation, circular sample window,
// serial window scan and a single restoring divider. Depends on design/ecgphr_pkg.sv
// and design/ecg_period_heart_rate_assert.svh.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_cmd, req_sample
//   rsp      out        rsp_valid/rsp_stall   rsp_bpm, rsp_rate_valid
//   csr      in         csr_we                csr_index, csr_wdata
//
// A sample word is taken without stalling the input. A query word holds the input stalled
// through the window scan (one memory read a cycle), the multiply state, BPM_W = 16
// divider steps and the state that loads the result, which waits while the
// result register is full; a query that finds no period skips the divider.
// The window needs no clearing pass after reset: a fill count marks which
// entries were written, and unwritten entries read as zero.
// The computed rate waits in the result register under rsp_stall; sample words
// are taken meanwhile, and a second query is taken and scanned, but then holds
// the input stalled until that register is free.
module ecg_period_heart_rate
   import ecgphr_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BPM_W-1:0]      rsp_bpm,
   output logic                  rsp_rate_valid,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int DEN_W  = IDX_W + PER_W;
   localparam int STEP_W = $clog2(BPM_W);

   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BPM_W - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // Configuration registers.
   logic [DEC_W-1:0] decimation_ff;
   logic [THR_W-1:0] threshold_ff;
   logic [PER_W-1:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff <= DECIMATION_RST;
         threshold_ff  <= THRESHOLD_RST;
         period_ff     <= PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECIMATION: decimation_ff <= csr_wdata[DEC_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[THR_W-1:0];
            CSR_PERIOD:     period_ff     <= csr_wdata[PER_W-1:0];
            default:        ;
         endcase
      end
   end

   logic [2:0] state_ff, state_in;

   logic req_take;
   logic take_sample;
   logic take_query;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign take_sample = req_take && (req_cmd == CMD_SAMPLE);
   assign take_query  = req_take && (req_cmd == CMD_QUERY);

   // Decimation and window bookkeeping. The window is a circular buffer whose
   // head points at the newest sample; logical entry i lives at head - i.
   logic [DEC_W-1:0] skip_ff;
   logic [IDX_W-1:0] head_ff;
   logic [CNT_W-1:0] count_ff;
   logic             keep;
   logic [IDX_W-1:0] head_in;

   assign keep    = take_sample && (skip_ff >= decimation_ff);
   assign head_in = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (take_sample) begin
         if (keep) begin
            skip_ff <= '0;
            head_ff <= head_in;
            if (count_ff != CNT_FULL) begin
               count_ff <= count_ff + 1'b1;
            end
         end else begin
            skip_ff <= skip_ff + 1'b1;
         end
      end
   end

   // Window memory: one write port, one registered read port.
   logic [SAMPLE_W-1:0] win_mem [WINDOW];
   logic [IDX_W-1:0]    addr_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (keep) begin
         win_mem[head_in] <= req_sample;
      end
      rd_data_ff <= win_mem[addr_ff];
   end

   // Read issue side of the scan: logical index and physical address.
   logic [IDX_W-1:0] iss_idx_ff;
   logic             iss_on_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_on_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else if (take_query) begin
         iss_on_ff   <= 1'b1;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= iss_on_ff;
         if (iss_on_ff && iss_idx_ff == IDX_LAST) begin
            iss_on_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_query) begin
         iss_idx_ff <= '0;
         addr_ff    <= head_ff;
      end else if (iss_on_ff) begin
         iss_idx_ff <= iss_idx_ff + 1'b1;
         addr_ff    <= (addr_ff == '0) ? IDX_LAST : addr_ff - 1'b1;
      end
      rd_idx_ff <= iss_idx_ff;
   end

   // Compare side of the scan: one neighbor difference per cycle.
   logic [SAMPLE_W-1:0] cur_data;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [SAMPLE_W-1:0] mag;
   logic                quiet;
   logic                active;
   logic                diff_on;
   logic [IDX_W-1:0]    diff_idx;
   logic                have_start_ff, have_finish_ff, signal_ff;
   logic [IDX_W-1:0]    start_ff, finish_ff;

   assign cur_data = (CNT_W'(rd_idx_ff) < count_ff) ? rd_data_ff : '0;
   assign mag      = (cur_data >= prev_ff) ? cur_data - prev_ff : prev_ff - cur_data;
   assign quiet    = (mag < threshold_ff);
   assign active   = (mag > threshold_ff);
   assign diff_on  = rd_valid_ff && (rd_idx_ff != '0);
   assign diff_idx = rd_idx_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset || take_query) begin
         have_start_ff  <= 1'b0;
         have_finish_ff <= 1'b0;
         signal_ff      <= 1'b0;
      end else if (diff_on) begin
         if (!signal_ff) begin
            if (!have_start_ff && quiet) begin
               have_start_ff <= 1'b1;
            end
            if (active) begin
               signal_ff <= 1'b1;
            end
         end else if (!have_finish_ff && quiet) begin
            have_finish_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prev_ff <= cur_data;
      end
      if (diff_on && !signal_ff && !have_start_ff && quiet) begin
         start_ff <= diff_idx;
      end
      if (diff_on && signal_ff && !have_finish_ff && quiet) begin
         finish_ff <= diff_idx;
      end
   end

   // Single restoring divider: 60000 / (span * period), one quotient bit a step.
   logic             found;
   logic [DEN_W-1:0] denom_ff;
   logic [DEN_W:0]   rem_ff;
   logic [BPM_W-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign found = have_start_ff && have_finish_ff;
   assign trial = {rem_ff[DEN_W-1:0], quo_ff[BPM_W-1]};
   assign fits  = (trial >= {1'b0, denom_ff});

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         denom_ff <= DEN_W'(finish_ff - start_ff) * DEN_W'(period_ff);
         rem_ff   <= '0;
         quo_ff   <= BPM_NUMERATOR;
         step_ff  <= '0;
      end else if (state_ff == ST_DIV) begin
         rem_ff  <= fits ? trial - {1'b0, denom_ff} : trial;
         quo_ff  <= {quo_ff[BPM_W-2:0], fits};
         step_ff <= step_ff + 1'b1;
      end
   end

   // Result register.
   logic             rsp_valid_ff;
   logic [BPM_W-1:0] rsp_bpm_ff;
   logic             rsp_rate_valid_ff;
   logic             rsp_free;
   logic             load;
   logic [BPM_W-1:0] bpm_sel;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (state_ff == ST_OUT) && rsp_free;
   assign bpm_sel  = !found ? '0 : ((denom_ff == '0) ? BPM_MAX : quo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_bpm_ff        <= bpm_sel;
         rsp_rate_valid_ff <= found;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bpm        = rsp_bpm_ff;
   assign rsp_rate_valid = rsp_rate_valid_ff;

   // Sequencer. The last difference reaches the flags at the edge that leaves
   // the scan, so the period check is made in the multiply state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (take_query) state_in = ST_SCAN;
         ST_SCAN: if (rd_valid_ff && rd_idx_ff == IDX_LAST) state_in = ST_MUL;
         ST_MUL:  state_in = found ? ST_DIV : ST_OUT;
         ST_DIV:  if (step_ff == STEP_LAST) state_in = ST_OUT;
         ST_OUT:  if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `include "ecg_period_heart_rate_assert.svh"

   `ECGPHR_ASSERT_SAME(a_finish_after_start, have_finish_ff && have_start_ff, finish_ff > start_ff, "period finish not after its start")
   `ECGPHR_ASSERT_NEXT(a_query_starts_scan, take_query, state_ff == ST_SCAN && iss_on_ff, "query did not start the scan")
   `ECGPHR_ASSERT_NEXT(a_invalid_rate_zero, load && !found, rsp_valid && !rsp_rate_valid && rsp_bpm == '0, "invalid rate with nonzero bpm")
   `ECGPHR_ASSERT_SAME(a_scan_only_busy, iss_on_ff || rd_valid_ff, state_ff == ST_SCAN, "memory scan active outside the scan state")

endmodule

>>> verif/ecg_period_heart_rate_test.sv
// Self-checking testbench for the ECG period and heart-rate block.
// Needs design/ecgphr_pkg.sv and design/ecg_period_heart_rate.sv; reads nothing else.
`timescale 1ns / 100ps

module ecg_period_heart_rate_test;
   import ecgphr_pkg::*;

   localparam int WIN          = WINDOW_DEFAULT;
   // A query scans the whole window and then divides; this margin covers that.
   localparam int DRAIN_CYCLES = WIN + 40;
   localparam int HOLD_CYCLES  = 800;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_WORDS = 530;
   // Index 3 has no register behind it; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [BPM_W-1:0] bpm;
      logic             rate_valid;
   } heart_rate_type;

   // Every input of the block starts at a known value.
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_cmd        = CMD_SAMPLE;
   logic [SAMPLE_W-1:0]   req_sample     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [BPM_W-1:0]      rsp_bpm;
   logic                  rsp_rate_valid;
   logic                  csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_DECIMATION;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // Our own copy of the registers and of the sample history.
   logic [DEC_W-1:0]    cfg_decimation = DECIMATION_RST;
   logic [THR_W-1:0]    cfg_threshold  = THRESHOLD_RST;
   logic [PER_W-1:0]    cfg_period     = PERIOD_RST;
   logic [DEC_W-1:0]    skip_count     = '0;
   int                  fill_count     = 0;
   logic [SAMPLE_W-1:0] win_mem [0:WIN-1];

   heart_rate_type pending_rates[$];

   int  mismatches    = 0;
   int  rates_checked = 0;
   int  queries_sent  = 0;
   int  samples_kept  = 0;
   int  words_counted = 0;
   int  reg_writes    = 0;
   int  cycle_count   = 0;
   // While calm is set, neither side inserts random idle cycles.
   bit  calm          = 1'b0;
   int  hold_requests = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;

   ecg_period_heart_rate dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_cmd, .req_sample,
      .rsp_valid, .rsp_stall, .rsp_bpm, .rsp_rate_valid,
      .csr_we, .csr_index, .csr_wdata
   );

   always #2 clock = ~clock;

   // The run may not hang: past the cycle limit it ends as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d rates outstanding",
                  cycle_count, pending_rates.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Shifts one sample into the history unless decimation drops it.
   // Returns whether the sample was kept.
   function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] value);
      if (skip_count < cfg_decimation) begin
         skip_count = skip_count + 1'b1;
         return 1'b0;
      end
      skip_count = '0;
      if (fill_count < WIN - 1)
         fill_count++;
      for (int i = fill_count; i > 0; i--)
         win_mem[i] = win_mem[i - 1];
      win_mem[0] = value;
      return 1'b1;
   endfunction

   // Walks the neighbor differences from the newest pair to the oldest and
   // derives the heart rate from the first quiet difference before the first active
   // one, and the first quiet one after that burst.
   function automatic heart_rate_type predict_rate();
      heart_rate_type rate;
      int          d, mag, first_quiet, end_quiet, denom, thr;
      bit          have_first, have_end, burst_seen;
      rate        = '0;
      thr         = int'(cfg_threshold);
      have_first  = 1'b0;
      have_end    = 1'b0;
      burst_seen  = 1'b0;
      first_quiet = 0;
      end_quiet   = 0;
      for (int i = 0; i < WIN - 1; i++) begin
         d   = int'(win_mem[i + 1]) - int'(win_mem[i]);
         mag = (d < 0) ? -d : d;
         if (!burst_seen) begin
            if (!have_first && mag < thr) begin
               have_first  = 1'b1;
               first_quiet = i;
            end
            if (mag > thr)
               burst_seen = 1'b1;
         end else if (!have_end && mag < thr) begin
            have_end  = 1'b1;
            end_quiet = i;
         end
      end
      if (have_first && have_end) begin
         denom = (end_quiet - first_quiet) * int'(cfg_period);
         // A zero period cannot be divided by; the rate saturates instead.
         if (denom == 0)
            rate.bpm = BPM_MAX;
         else
            rate.bpm = BPM_W'(int'(BPM_NUMERATOR) / denom);
         rate.rate_valid = 1'b1;
      end
      return rate;
   endfunction

   // Sends one word and updates the prediction at the edge that takes it.
   // Valid stays high afterwards so that back-to-back words need no toggle.
   task automatic send_word(input logic cmd, input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 28)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_sample <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_counted++;
      if (cmd == CMD_QUERY) begin
         pending_rates.push_back(predict_rate());
         queries_sent++;
      end else if (absorb_sample(value)) begin
         samples_kept++;
      end
   endtask

   task automatic send_query();
      send_word(CMD_QUERY, SAMPLE_W'($urandom_range(0, 1023)));
   endtask

   // Writes one register; called only while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DECIMATION: cfg_decimation = data;
         CSR_THRESHOLD:  cfg_threshold  = data[THR_W-1:0];
         CSR_PERIOD:     cfg_period     = data;
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // Stops offering words, waits for every predicted rate, then lets the
   // block finish whatever sample word it may still be digesting.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Moves a level by the given magnitude, up or down, staying within 10 bits.
   function automatic int step_level(input int lvl, input int mag);
      int up, down;
      up   = lvl + mag;
      down = lvl - mag;
      if (down < 0 || (up <= 1023 && $urandom_range(0, 1) == 1))
         return (up > 1023) ? 1023 : up;
      return down;
   endfunction

   // Sends one heartbeat-like stretch, oldest first: a quiet baseline, a burst
   // of large steps, a second quiet run, and a few newest steps that sit exactly
   // on the threshold or, now and then, are active and so spoil the period.
   task automatic send_beat();
      int lvl, thr, quiet_mag, burst_mag;
      thr = int'(cfg_threshold);
      lvl = $urandom_range(150, 850);
      repeat ($urandom_range(2, 12)) begin
         quiet_mag = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
         lvl = step_level(lvl, quiet_mag);
         send_word(CMD_SAMPLE, SAMPLE_W'(lvl));
      end
      repeat ($urandom_range(1, 5)) begin
         burst_mag = (thr >= 1023) ? 1023 : $urandom_range(thr + 1, 1023);
         lvl = step_level(lvl, burst_mag);
         send_word(CMD_SAMPLE, SAMPLE_W'(lvl));
      end
      repeat ($urandom_range(2, 12)) begin
         quiet_mag = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
         lvl = step_level(lvl, quiet_mag);
         send_word(CMD_SAMPLE, SAMPLE_W'(lvl));
      end
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 9) == 0)
            burst_mag = (thr >= 1023) ? 1023 : $urandom_range(thr + 1, 1023);
         else
            burst_mag = thr;
         lvl = step_level(lvl, burst_mag);
         send_word(CMD_SAMPLE, SAMPLE_W'(lvl));
      end
   endtask

   // Hand-built windows at the reset settings: the empty window, a clean
   // period, a burst with no quiet lead-in, and a difference on the threshold.
   task automatic test_window_shapes();
      // All entries are zero: quiet at once, but no burst, so no period.
      send_query();
      // Flat, one spike, flat: a period of three samples.
      send_word(CMD_SAMPLE, 10'd100);
      send_word(CMD_SAMPLE, 10'd100);
      send_word(CMD_SAMPLE, 10'd600);
      send_word(CMD_SAMPLE, 10'd100);
      send_word(CMD_SAMPLE, 10'd100);
      send_query();
      // Full-scale step as the newest pair: the burst comes before any quiet one.
      send_word(CMD_SAMPLE, 10'd0);
      send_word(CMD_SAMPLE, 10'd1023);
      send_query();
      // The newest difference equals the threshold and must not open the period.
      send_word(CMD_SAMPLE, 10'd900);
      send_word(CMD_SAMPLE, 10'd900);
      send_word(CMD_SAMPLE, 10'd542);
      send_word(CMD_SAMPLE, 10'd542);
      send_word(CMD_SAMPLE, 10'd500);
      send_query();
      settle();
   endtask

   // Each register at its extremes, plus a zero period, a threshold written
   // with junk in the upper bits, and a write to the unused index.
   task automatic test_register_extremes();
      write_reg(CSR_PERIOD, 16'd1);
      send_query();
      settle();
      write_reg(CSR_PERIOD, 16'hFFFF);
      send_query();
      settle();
      write_reg(CSR_PERIOD, 16'd0);
      send_query();
      settle();
      write_reg(CSR_PERIOD, PERIOD_RST);
      write_reg(CSR_THRESHOLD, 16'hFC00 | 16'd42);
      write_reg(CSR_UNUSED, 16'h5A5A);
      send_query();
      settle();
      // A zero threshold makes nothing quiet; the top one makes nothing active.
      write_reg(CSR_THRESHOLD, 16'd0);
      send_query();
      settle();
      write_reg(CSR_THRESHOLD, 16'd1023);
      send_query();
      settle();
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(THRESHOLD_RST));
      // At the widest decimation every one of these samples is dropped.
      write_reg(CSR_DECIMATION, 16'hFFFF);
      repeat (6) send_word(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
      send_query();
      settle();
      write_reg(CSR_DECIMATION, 16'd2);
      repeat (9) send_word(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
      send_query();
      settle();
      write_reg(CSR_DECIMATION, 16'd0);
   endtask

   // Random settings per phase; most words form beats followed by a query,
   // the rest are noise with random commands. One phase runs with no idling.
   task automatic test_random_beats();
      int target, phase, pick;
      target = words_counted + RANDOM_WORDS;
      phase  = 0;
      while (words_counted < target) begin
         pick = $urandom_range(0, 9);
         write_reg(CSR_DECIMATION, (pick < 7) ? 16'd0 : CSR_DATA_W'($urandom_range(1, 3)));
         pick = $urandom_range(0, 9);
         if (pick < 6)
            write_reg(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(8, 150)));
         else
            write_reg(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 1023)));
         pick = $urandom_range(0, 9);
         if (pick < 5)
            write_reg(CSR_PERIOD, CSR_DATA_W'($urandom_range(1, 300)));
         else if (pick < 8)
            write_reg(CSR_PERIOD, CSR_DATA_W'($urandom_range(300, 5000)));
         else
            write_reg(CSR_PERIOD, CSR_DATA_W'($urandom_range(1, 65535)));
         calm = (phase == 3);
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 9) < 8) begin
               send_beat();
               send_query();
            end else begin
               repeat ($urandom_range(3, 12)) begin
                  if ($urandom_range(0, 4) == 0)
                     send_query();
                  else
                     send_word(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
               end
            end
         end
         settle();
         calm = 1'b0;
         phase++;
      end
   endtask

   // The receiver holds off for a long stretch while queries keep coming, so
   // the result register stays full and a later query stalls the input.
   task automatic test_result_backlog();
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(THRESHOLD_RST));
      write_reg(CSR_PERIOD, 16'd5);
      hold_requests++;
      send_beat();
      send_query();
      repeat (6) send_word(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 1023)));
      send_query();
      send_beat();
      send_query();
      settle();
   endtask

   // Receiver side: random stalls, or a long counted hold when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
      end
   end

   // Every result word taken is checked against the oldest predicted rate.
   always @(posedge clock) begin
      heart_rate_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rates.size() == 0) begin
            $display("%0t: unexpected result word, bpm %0d, rate_valid %0b",
                     $time, rsp_bpm, rsp_rate_valid);
            mismatches++;
         end else begin
            want = pending_rates.pop_front();
            if (rsp_bpm !== want.bpm) begin
               $display("%0t: bpm expected %0d, actual %0d",
                        $time, want.bpm, rsp_bpm);
               mismatches++;
            end
            if (rsp_rate_valid !== want.rate_valid) begin
               $display("%0t: rate_valid expected %0b, actual %0b",
                        $time, want.rate_valid, rsp_rate_valid);
               mismatches++;
            end
            rates_checked++;
         end
      end
   end

   initial begin
      for (int i = 0; i < WIN; i++)
         win_mem[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_window_shapes();
      test_register_extremes();
      test_random_beats();
      test_result_backlog();
      settle();
      if (pending_rates.size() != 0) begin
         $display("%0d predicted rates never arrived", pending_rates.size());
         mismatches++;
      end
      $display("Sent %0d words: %0d queries and %0d kept samples.",
               words_counted, queries_sent, samples_kept);
      $display("Made %0d register writes and checked %0d rates, %0d mismatches.",
               reg_writes, rates_checked, mismatches);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/ecgphr_pkg.sv
design/ecg_period_heart_rate.sv
verif/ecg_period_heart_rate_test.sv
